// ----- hw/rtl/sitbd_pkg.sv -----
// ============================================================================
// sitbd_pkg: shared types and constants for signed integer to text
// Holds the state encoding, the register map, character codes and the
// reciprocal table used by the digit divider.
// ============================================================================
package sitbd_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd2;

    // register widths and reset values
    localparam int BASE_W    = 5;
    localparam int SYM_IDX_W = 4;
    localparam int NUM_SYMS  = 16;
    localparam int CHAR_W    = 8;
    localparam logic [BASE_W-1:0]     RST_BASE_SIZE = 5'd10;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_LO  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_HI  = 64'h0000_0000_0000_3938;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // reciprocal scaling
    localparam int RECIP_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_FIX,
        ST_SIGN,
        ST_EMIT,
        ST_INVAL
    } t_state;

    // floor(2^32 / b) for bases 2..16, zero where the base is meaningless
    function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] b);
        case (b)
            5'd2:    recip = 32'h8000_0000;
            5'd3:    recip = 32'h5555_5555;
            5'd4:    recip = 32'h4000_0000;
            5'd5:    recip = 32'h3333_3333;
            5'd6:    recip = 32'h2AAA_AAAA;
            5'd7:    recip = 32'h2492_4924;
            5'd8:    recip = 32'h2000_0000;
            5'd9:    recip = 32'h1C71_C71C;
            5'd10:   recip = 32'h1999_9999;
            5'd11:   recip = 32'h1745_D174;
            5'd12:   recip = 32'h1555_5555;
            5'd13:   recip = 32'h13B1_3B13;
            5'd14:   recip = 32'h1249_2492;
            5'd15:   recip = 32'h1111_1111;
            5'd16:   recip = 32'h1000_0000;
            default: recip = '0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/sitbd_if.sv -----
// ============================================================================
// sitbd_if: valid/ready channels of the signed integer to text block
// One channel carries numbers in, the other carries text characters out.
// ============================================================================
interface sitbd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       alphabet_invalid;

    modport source (output valid, output out_char, output last, output alphabet_invalid,
                    input ready);
    modport sink   (input valid, input out_char, input last, input alphabet_invalid,
                    output ready);
endinterface

// ----- hw/rtl/sitbd_div.sv -----
// ============================================================================
// sitbd_div: divide of a magnitude by a small base
// Multiplies by a table reciprocal, registers the product, then fixes the
// estimate with one compare and subtract to give quotient and remainder.
// ============================================================================
module sitbd_div #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_BASE   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [VALUE_BITS-1:0]            i_num,
    input  logic [sitbd_pkg::BASE_W-1:0]     i_base,
    output logic                             o_done,
    output logic [VALUE_BITS-1:0]            o_quot,
    output logic [$clog2(MAX_BASE)-1:0]      o_rem
);

    localparam int RW = sitbd_pkg::RECIP_W;
    localparam int PW = VALUE_BITS + RW;
    localparam int DW = $clog2(MAX_BASE);

    logic                          r_busy;
    logic [PW-1:0]                 r_prod;
    logic [VALUE_BITS-1:0]         r_num;
    logic [sitbd_pkg::BASE_W-1:0]  r_base;

    logic [VALUE_BITS-1:0] w_qest;
    logic [VALUE_BITS-1:0] w_qb;
    logic [VALUE_BITS-1:0] w_rest;
    logic [VALUE_BITS-1:0] w_base_x;
    logic [VALUE_BITS-1:0] w_rfix;
    logic                  w_fix;

    // control: result is ready in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_num) * PW'(sitbd_pkg::recip(i_base));
            r_num  <= i_num;
            r_base <= i_base;
        end
    end

    // estimate is the true quotient or one below it
    assign w_base_x = VALUE_BITS'(r_base);
    assign w_qest   = r_prod[PW-1:RW];
    assign w_qb     = VALUE_BITS'(w_qest * w_base_x);
    assign w_rest   = r_num - w_qb;
    assign w_fix    = (w_rest >= w_base_x);
    assign w_rfix   = w_fix ? (w_rest - w_base_x) : w_rest;

    assign o_done = r_busy;
    assign o_quot = w_fix ? (w_qest + VALUE_BITS'(1)) : w_qest;
    assign o_rem  = w_rfix[DW-1:0];

endmodule

// ----- hw/rtl/signed_int_to_base_digits.sv -----
// ============================================================================
// signed_int_to_base_digits: signed integer to text in a configurable base
// Checks the alphabet, splits the magnitude into digits and streams the
// characters out, minus sign first for negative numbers.
// ============================================================================
// One number is taken at a time. After a number is accepted the block checks
// the alphabet, then runs each digit through the shared reciprocal divider
// (multiply, then correct), passes the sign slot, and sends one digit
// character per cycle through the single output register when the sink is
// ready. The next number is accepted while the last character of the
// previous one still waits in the output register.
module signed_int_to_base_digits #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    sitbd_in_if.sink                              i_in,
    sitbd_out_if.source                           o_out,
    input  logic                                  i_cfg_we,
    input  logic [sitbd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sitbd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DW = $clog2(MAX_BASE);
    localparam int NW = $clog2(VALUE_BITS + 1);
    localparam int IW = $clog2(VALUE_BITS);
    localparam int BW = sitbd_pkg::BASE_W;
    localparam int CW = sitbd_pkg::CHAR_W;
    localparam int SW = sitbd_pkg::SYM_IDX_W;

    // configuration registers
    logic [BW-1:0]                     r_base_size;
    logic [sitbd_pkg::CFG_DATA_W-1:0]  r_alpha_lo;
    logic [sitbd_pkg::CFG_DATA_W-1:0]  r_alpha_hi;

    // sequencer and datapath
    sitbd_pkg::t_state     r_state;
    sitbd_pkg::t_state     n_state;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic [NW-1:0]         r_nd;
    logic [DW-1:0]         r_dig [VALUE_BITS];

    // output register
    logic          r_out_valid;
    logic [CW-1:0] r_out_char;
    logic          r_out_last;
    logic          r_out_inv;

    logic [CW-1:0]         w_sym [sitbd_pkg::NUM_SYMS];
    logic                  w_alpha_ok;
    logic [VALUE_BITS-1:0] w_raw;
    logic                  w_accept;
    logic                  w_in_ready;
    logic                  w_slot;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_div_quot;
    logic [DW-1:0]         w_div_rem;
    logic                  w_dig_we;
    logic                  w_nd_dec;
    logic                  w_load;
    logic [CW-1:0]         w_ld_char;
    logic                  w_ld_last;
    logic                  w_ld_inv;
    logic [IW-1:0]         w_rd_idx;
    logic [SW-1:0]         w_sym_idx;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= sitbd_pkg::RST_BASE_SIZE;
            r_alpha_lo  <= sitbd_pkg::RST_ALPHA_LO;
            r_alpha_hi  <= sitbd_pkg::RST_ALPHA_HI;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sitbd_pkg::CFG_BASE_SIZE: r_base_size <= i_cfg_data[BW-1:0];
                sitbd_pkg::CFG_ALPHA_LO:  r_alpha_lo  <= i_cfg_data;
                sitbd_pkg::CFG_ALPHA_HI:  r_alpha_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // symbol table view of the alphabet registers
    always_comb begin
        for (int k = 0; k < sitbd_pkg::NUM_SYMS; k++) begin
            if (k < 8) begin
                w_sym[k] = r_alpha_lo[8*k +: 8];
            end else begin
                w_sym[k] = r_alpha_hi[8*(k-8) +: 8];
            end
        end
    end

    // alphabet check: size, forbidden symbols, repeats
    always_comb begin
        w_alpha_ok = (r_base_size >= BW'(2)) && (r_base_size <= BW'(MAX_BASE));
        for (int i = 0; i < sitbd_pkg::NUM_SYMS; i++) begin
            if (BW'(i) < r_base_size) begin
                if (w_sym[i] == sitbd_pkg::CH_NUL || w_sym[i] == sitbd_pkg::CH_PLUS ||
                    w_sym[i] == sitbd_pkg::CH_MINUS || w_sym[i] == sitbd_pkg::CH_SPACE ||
                    (w_sym[i] >= sitbd_pkg::CH_TAB && w_sym[i] <= sitbd_pkg::CH_CR)) begin
                    w_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sitbd_pkg::NUM_SYMS; j++) begin
                    if (BW'(j) < r_base_size && w_sym[j] == w_sym[i]) begin
                        w_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // shared divider
    sitbd_div #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_BASE   (MAX_BASE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_mag),
        .i_base  (r_base_size),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    assign w_raw     = i_in.value[VALUE_BITS-1:0];
    assign w_accept  = i_in.valid && w_in_ready;
    assign w_slot    = !r_out_valid || o_out.ready;
    assign w_rd_idx  = IW'(r_nd - NW'(1));
    assign w_sym_idx = SW'(r_dig[w_rd_idx]);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer controls
    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_dig_we    = 1'b0;
        w_nd_dec    = 1'b0;
        w_load      = 1'b0;
        w_ld_char   = sitbd_pkg::CH_NUL;
        w_ld_last   = 1'b0;
        w_ld_inv    = 1'b0;
        case (r_state)
            sitbd_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = sitbd_pkg::ST_CHECK;
                end
            end
            sitbd_pkg::ST_CHECK: begin
                n_state = w_alpha_ok ? sitbd_pkg::ST_MUL : sitbd_pkg::ST_INVAL;
            end
            sitbd_pkg::ST_MUL: begin
                w_div_start = 1'b1;
                n_state     = sitbd_pkg::ST_FIX;
            end
            sitbd_pkg::ST_FIX: begin
                if (w_div_done) begin
                    w_dig_we = 1'b1;
                    n_state  = (w_div_quot == '0) ? sitbd_pkg::ST_SIGN : sitbd_pkg::ST_MUL;
                end
            end
            sitbd_pkg::ST_SIGN: begin
                if (!r_neg) begin
                    n_state = sitbd_pkg::ST_EMIT;
                end else if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_char = sitbd_pkg::CH_MINUS;
                    n_state   = sitbd_pkg::ST_EMIT;
                end
            end
            sitbd_pkg::ST_EMIT: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_char = w_sym[w_sym_idx];
                    w_ld_last = (r_nd == NW'(1));
                    w_nd_dec  = 1'b1;
                    if (r_nd == NW'(1)) begin
                        n_state = sitbd_pkg::ST_IDLE;
                    end
                end
            end
            sitbd_pkg::ST_INVAL: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_char = sitbd_pkg::CH_NUL;
                    w_ld_last = 1'b1;
                    w_ld_inv  = 1'b1;
                    n_state   = sitbd_pkg::ST_IDLE;
                end
            end
            default: n_state = sitbd_pkg::ST_IDLE;
        endcase
    end

    // digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd <= '0;
        end else if (w_accept) begin
            r_nd <= '0;
        end else if (w_dig_we) begin
            r_nd <= r_nd + NW'(1);
        end else if (w_nd_dec) begin
            r_nd <= r_nd - NW'(1);
        end
    end

    // magnitude, sign and digit buffer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_raw[VALUE_BITS-1];
            r_mag <= w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
        end else if (w_dig_we) begin
            r_mag <= w_div_quot;
        end
        if (w_dig_we) begin
            r_dig[r_nd[IW-1:0]] <= w_div_rem;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_char <= w_ld_char;
            r_out_last <= w_ld_last;
            r_out_inv  <= w_ld_inv;
        end
    end

    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.out_char         = r_out_char;
    assign o_out.last             = r_out_last;
    assign o_out.alphabet_invalid = r_out_inv;

    // an invalid-alphabet beat is always a lone zero byte
    a_inval_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_inv |-> r_out_char == sitbd_pkg::CH_NUL && r_out_last)
        else $error("invalid alphabet beat is not a final zero byte");

    // digit count never exceeds the buffer
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= NW'(VALUE_BITS))
        else $error("digit count out of range");

    // each digit written is below the base
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dig_we |-> BW'(w_div_rem) < r_base_size)
        else $error("divider remainder not below base");

endmodule

// ----- test/tb.sv -----
// ============================================================================
// tb: regression bench for signed_int_to_base_digits
// Feeds signed numbers over the input channel and checks every character
// beat on the output channel against an in-bench formatter or text typed
// in the table. A directed table covers the reset alphabet, base extremes,
// edge symbols and each alphabet rejection rule. Random phases then reprogram
// the alphabet and stream numbers with random idle cycles on both channels.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BASE    = 16;
    localparam int RAND_ITEMS  = 140;
    localparam int TAIL_CYCLES = 3 * 33 + 10;
    localparam int MAX_REPORTS = 10;

    // register index that maps to no register
    localparam logic [sitbd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic signed [31:0] EDGE_VALUES [7] = '{
        32'sd0, 32'sd1, -32'sd1, INT_MAX, INT_MIN, INT_MAX - 1, INT_MIN + 1
    };

    // symbols the alphabet check rejects
    localparam logic [sitbd_pkg::CHAR_W-1:0] BAD_SYMS [9] = '{
        sitbd_pkg::CH_NUL, sitbd_pkg::CH_PLUS, sitbd_pkg::CH_MINUS, sitbd_pkg::CH_TAB,
        8'h0A, 8'h0B, 8'h0C, sitbd_pkg::CH_CR, sitbd_pkg::CH_SPACE
    };

    typedef struct packed {
        logic [sitbd_pkg::CHAR_W-1:0] ch;
        logic                         last;
        logic                         inval;
    } t_text_beat;

    typedef enum logic [1:0] {
        ROW_REG,    // register write
        ROW_NUM,    // number, expectation from the formatter
        ROW_TEXT,   // number, expected text given in the row
        ROW_INVAL   // number, rejected alphabet expected
    } t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [sitbd_pkg::CFG_IDX_W-1:0] idx;
        logic [63:0]                     data;
        logic [31:0]                     value;
        logic [95:0]                     text;
    } t_row;

    localparam int N_ROWS = 43;

    // directed stimulus
    t_row stim_rows [N_ROWS] = '{
        // reset alphabet, decimal
        '{ROW_TEXT,  '0, 64'd0, 32'sd0,   "0"},
        '{ROW_TEXT,  '0, 64'd0, -32'sd1,  "-1"},
        '{ROW_TEXT,  '0, 64'd0, INT_MAX,  "2147483647"},
        '{ROW_TEXT,  '0, 64'd0, INT_MIN,  "-2147483648"},
        '{ROW_NUM,   '0, 64'd0, 32'sh1234_5678, ""},
        // binary, upper register bits set
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'hFFFF_FFFF_FFFF_FFE2, 32'sd0, ""},
        '{ROW_NUM,   '0, 64'd0, INT_MIN,  ""},
        '{ROW_NUM,   '0, 64'd0, INT_MAX,  ""},
        '{ROW_TEXT,  '0, 64'd0, 32'sd5,   "101"},
        '{ROW_TEXT,  '0, 64'd0, -32'sd2,  "-10"},
        // base 16 with edge bytes just outside the rejected ranges
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h6362_6121_1F0E_0801, 32'sd0, ""},
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_HI,  64'h7778_7A79_2A2E_2CFF, 32'sd0, ""},
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd16, 32'sd0, ""},
        '{ROW_NUM,   '0, 64'd0, -32'sd1,  ""},
        '{ROW_NUM,   '0, 64'd0, INT_MAX,  ""},
        '{ROW_NUM,   '0, 64'd0, INT_MIN,  ""},
        // plus sign past the active symbols is harmless
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_2B63_6261, 32'sd0, ""},
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd3,  32'sd0, ""},
        '{ROW_TEXT,  '0, 64'd0, -32'sd5,  "-bc"},
        // plus sign inside the active symbols
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd4,  32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd7,   ""},
        // minus sign
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_642D_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd7,   ""},
        // tab
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_6409_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, -32'sd7,  ""},
        // carriage return
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_640D_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd0,   ""},
        // space
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_6420_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd1,   ""},
        // zero byte
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_6400_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, INT_MIN,  ""},
        // vertical tab, inside the whitespace range
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_640B_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, INT_MAX,  ""},
        // repeated symbol
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_6461_6261, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd3,   ""},
        // clean base 4
        '{ROW_REG,   sitbd_pkg::CFG_ALPHA_LO,  64'h0000_0000_6463_6261, 32'sd0, ""},
        '{ROW_TEXT,  '0, 64'd0, 32'sd27,  "bcd"},
        // base sizes out of range
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd1,  32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd9,   ""},
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd0,  32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, -32'sd9,  ""},
        '{ROW_REG,   sitbd_pkg::CFG_BASE_SIZE, 64'd17, 32'sd0, ""},
        '{ROW_INVAL, '0, 64'd0, 32'sd12,  ""}
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [sitbd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [sitbd_pkg::CFG_DATA_W-1:0] cfg_data;

    sitbd_in_if  num_if ();
    sitbd_out_if txt_if ();

    // bench copy of the registers
    logic [sitbd_pkg::BASE_W-1:0]     base_q;
    logic [sitbd_pkg::CFG_DATA_W-1:0] alpha_lo_q;
    logic [sitbd_pkg::CFG_DATA_W-1:0] alpha_hi_q;

    t_text_beat staged[$];
    t_text_beat expected_beats[$];
    t_text_beat next_beat;
    int         fail_count = 0;
    bit         calm = 1'b0;

    signed_int_to_base_digits #(
        .MAX_BASE   (MAX_BASE),
        .VALUE_BITS (32)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (num_if),
        .o_out      (txt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // formatter
    // ------------------------------------------------------------------------
    function automatic logic [sitbd_pkg::CHAR_W-1:0] symbol_of(input int unsigned k);
        return (k < 8) ? alpha_lo_q[8*k +: 8] : alpha_hi_q[8*(k-8) +: 8];
    endfunction

    function automatic bit symbol_ok(input logic [sitbd_pkg::CHAR_W-1:0] c);
        return !(c == sitbd_pkg::CH_NUL || c == sitbd_pkg::CH_PLUS ||
                 c == sitbd_pkg::CH_MINUS || c == sitbd_pkg::CH_SPACE ||
                 (c >= sitbd_pkg::CH_TAB && c <= sitbd_pkg::CH_CR));
    endfunction

    function automatic bit alphabet_usable();
        if (base_q < 2 || base_q > MAX_BASE)
            return 1'b0;
        for (int i = 0; i < base_q; i++) begin
            if (!symbol_ok(symbol_of(i)))
                return 1'b0;
            for (int j = i + 1; j < base_q; j++)
                if (symbol_of(j) == symbol_of(i))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // characters of one number, left in staged
    function automatic void format_number(input logic [31:0] v);
        logic [31:0]  mag;
        int unsigned  radix;
        int unsigned  digit_q[$];
        staged.delete();
        if (!alphabet_usable()) begin
            staged.push_back('{sitbd_pkg::CH_NUL, 1'b1, 1'b1});
            return;
        end
        radix = base_q;
        mag = v[31] ? -v : v;
        if (v[31])
            staged.push_back('{sitbd_pkg::CH_MINUS, 1'b0, 1'b0});
        do begin
            digit_q.push_front(mag % radix);
            mag = mag / radix;
        end while (mag != 0);
        foreach (digit_q[i])
            staged.push_back('{symbol_of(digit_q[i]), i == digit_q.size() - 1, 1'b0});
    endfunction

    // characters given directly by a table row
    function automatic void stage_typed(input logic [95:0] text, input bit inval);
        logic [sitbd_pkg::CHAR_W-1:0] c;
        staged.delete();
        if (inval) begin
            staged.push_back('{sitbd_pkg::CH_NUL, 1'b1, 1'b1});
            return;
        end
        for (int k = 11; k >= 0; k--) begin
            c = text[8*k +: 8];
            if (c != sitbd_pkg::CH_NUL)
                staged.push_back('{c, 1'b0, 1'b0});
        end
        staged[staged.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [31:0] v);
        while (!calm && $urandom_range(0, 99) < 13) begin
            num_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        num_if.valid <= 1'b1;
        num_if.value <= v;
        do @(posedge i_clk); while (num_if.ready !== 1'b1);
        foreach (staged[i])
            expected_beats.push_back(staged[i]);
    endtask

    // registers change only once every pending character is out
    task automatic write_reg(input logic [sitbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        num_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sitbd_pkg::CFG_BASE_SIZE: base_q     = data[sitbd_pkg::BASE_W-1:0];
            sitbd_pkg::CFG_ALPHA_LO:  alpha_lo_q = data;
            sitbd_pkg::CFG_ALPHA_HI:  alpha_hi_q = data;
            default:                  ;
        endcase
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1: return EDGE_VALUES[$urandom_range(0, 6)];
            2, 3, 4: begin
                mag = $urandom_range(0, 300);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    // new alphabet: mostly clean, some broken
    task automatic random_alphabet(output int n_items);
        logic [sitbd_pkg::CHAR_W-1:0] syms [16];
        bit   [255:0]                 used;
        logic [sitbd_pkg::CHAR_W-1:0] c;
        logic [sitbd_pkg::BASE_W-1:0] radix;
        logic [63:0]                  lo, hi, base_word;
        int                           shape, pos, first;
        shape = $urandom_range(0, 9);
        used  = '0;
        case (shape)
            0:       radix = 5'd2;
            1:       radix = 5'd16;
            9:       radix = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                                  : 5'($urandom_range(17, 31));
            default: radix = 5'($urandom_range(2, 16));
        endcase
        for (int i = 0; i < 16; i++) begin
            if (i < radix) begin
                do c = 8'($urandom_range(0, 255)); while (!symbol_ok(c) || used[c]);
                used[c] = 1'b1;
                syms[i] = c;
            end else begin
                syms[i] = 8'($urandom_range(0, 255));
            end
        end
        // one rejected symbol or one repeat
        if (shape == 7) begin
            pos = $urandom_range(0, radix - 1);
            if ($urandom_range(0, 1))
                syms[pos] = BAD_SYMS[$urandom_range(0, 8)];
            else
                syms[pos] = syms[(pos + 1 + $urandom_range(0, radix - 2)) % radix];
        end
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = syms[i];
            hi[8*i +: 8] = syms[i+8];
        end
        if (shape == 8) begin
            lo    = {$urandom, $urandom};
            hi    = {$urandom, $urandom};
            radix = 5'($urandom_range(0, 31));
        end
        base_word = {$urandom, $urandom};
        base_word[sitbd_pkg::BASE_W-1:0] = radix;
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case ((first + k) % 3)
                0:       write_reg(sitbd_pkg::CFG_BASE_SIZE, base_word);
                1:       write_reg(sitbd_pkg::CFG_ALPHA_LO, lo);
                default: write_reg(sitbd_pkg::CFG_ALPHA_HI, hi);
            endcase
        end
        n_items = (shape >= 7) ? $urandom_range(3, 6) : $urandom_range(10, 20);
    endtask

    // ------------------------------------------------------------------------
    // output sink and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        txt_if.ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && txt_if.valid && txt_if.ready) begin
            if (expected_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat char %02h last %b inval %b", $realtime,
                             txt_if.out_char, txt_if.last, txt_if.alphabet_invalid);
            end else begin
                next_beat = expected_beats.pop_front();
                if (txt_if.out_char !== next_beat.ch || txt_if.last !== next_beat.last ||
                    txt_if.alphabet_invalid !== next_beat.inval) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp char %02h last %b inval %b, got %02h %b %b",
                                 $realtime, next_beat.ch, next_beat.last, next_beat.inval,
                                 txt_if.out_char, txt_if.last, txt_if.alphabet_invalid);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int rand_count;
        int n_items;
        num_if.valid = 1'b0;
        num_if.value = '0;
        txt_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        base_q       = sitbd_pkg::RST_BASE_SIZE;
        alpha_lo_q   = sitbd_pkg::RST_ALPHA_LO;
        alpha_hi_q   = sitbd_pkg::RST_ALPHA_HI;
        rand_count   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (stim_rows[r]) begin
            case (stim_rows[r].kind)
                ROW_REG: write_reg(stim_rows[r].idx, stim_rows[r].data);
                ROW_NUM: begin
                    format_number(stim_rows[r].value);
                    send_number(stim_rows[r].value);
                end
                ROW_TEXT: begin
                    stage_typed(stim_rows[r].text, 1'b0);
                    send_number(stim_rows[r].value);
                end
                default: begin
                    stage_typed('0, 1'b1);
                    send_number(stim_rows[r].value);
                end
            endcase
        end

        // random phases, with a stretch of full throughput in the middle
        while (rand_count < RAND_ITEMS) begin
            random_alphabet(n_items);
            repeat (n_items) begin
                logic [31:0] v;
                calm = (rand_count >= 60 && rand_count < 100);
                v = random_value();
                format_number(v);
                send_number(v);
                rand_count++;
            end
        end
        calm = 1'b0;

        num_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sitbd_pkg.sv
hw/rtl/sitbd_if.sv
hw/rtl/sitbd_div.sv
hw/rtl/signed_int_to_base_digits.sv
test/tb.sv
